### rtl/rmf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and codes for the 3x3 rank/mean pixel filter.
// Depends on nothing; the filter top level and its checker refer to it by scoped names.
package rmf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int CFG_W   = 11;                          // widest configuration register
    localparam int COL_W   = $clog2(MAX_WIDTH);           // column position / line address
    localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);       // effective frame width
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);      // row position and frame height

    localparam int CH_W   = 8;
    localparam int NUM_CH = 3;
    localparam int PIX_W  = CH_W * NUM_CH;
    localparam int LINE_W = 2 * PIX_W;                    // upper and middle line side by side

    localparam int SUM3_W = CH_W + 2;
    localparam int SUM9_W = CH_W + 4;

    // Sum of nine divided by nine: multiply by ceil(2^16 / 9) and drop 16 bits.
    // The error stays below 1/100 over the whole sum range, so the floor is exact.
    localparam int MEAN_RECIP   = 7282;
    localparam int MEAN_SHIFT   = 16;
    localparam int RECIP_W      = 13;
    localparam int PROD_W       = SUM9_W + RECIP_W;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FILTER_MODE  = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        MODE_MEAN = 2'd0,
        MODE_MIN  = 2'd1,
        MODE_MAX  = 2'd2,
        MODE_PASS = 2'd3
    } mode_t;

    // Where a result pixel comes from.
    typedef enum logic [2:0] {
        SRC_INPUT,
        SRC_UPPER,
        SRC_MIDDLE,
        SRC_CENTER,
        SRC_FILTER
    } src_t;

    typedef struct packed {
        logic             wr;     // pixel step: shift window, write line store
        logic             emit;   // produces a result beat
        src_t             src;
        logic             last;
        logic [COL_W-1:0] addr;
    } s1_ctrl_t;

    typedef struct packed {
        logic [SUM3_W-1:0] sum;
        logic [CH_W-1:0]   lo;
        logic [CH_W-1:0]   hi;
    } col_stat_t;

endpackage

### rtl/window_3x3_rank_mean_filter.sv
`timescale 1ns / 1ps
// 3x3 rank/mean filter for a raster-order RGB pixel stream, with its line store.
// Depends on rmf_pkg.
//
// The block takes one beat per clock unless the result side stalls: each pixel costs
// one read and one write of a single 1024 x 48 line memory (upper and middle line of the
// same column in one word), and the read of the next pixel overlaps the write of the one
// before it through a forwarding register. A result passes the line read, the window and
// column statistics and the filter arithmetic in turn, and a result beat normally lags
// its pixel by one row plus one pixel; after the last pixel of a frame, flush beats
// drain the remaining row plus one pixels. Frames narrower or shorter than three pixels
// pass straight through and flush beats then give nothing. Border pixels are copied
// unchanged. The line memory needs no clearing after reset. The user must write frame
// size and filter mode only while the block is idle; the block does not enforce this.
// A size write restarts the frame.
module window_3x3_rank_mean_filter (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [rmf_pkg::CFG_W-1:0]   cfg_data,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_command,
    input  logic [rmf_pkg::CH_W-1:0]    s_pixel_red,
    input  logic [rmf_pkg::CH_W-1:0]    s_pixel_green,
    input  logic [rmf_pkg::CH_W-1:0]    s_pixel_blue,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rmf_pkg::CH_W-1:0]    m_out_red,
    output logic [rmf_pkg::CH_W-1:0]    m_out_green,
    output logic [rmf_pkg::CH_W-1:0]    m_out_blue,
    output logic                        m_frame_last
);

    localparam int COL_W   = rmf_pkg::COL_W;
    localparam int ROW_W   = rmf_pkg::ROW_W;
    localparam int WIDTH_W = rmf_pkg::WIDTH_W;
    localparam int CH_W    = rmf_pkg::CH_W;
    localparam int NUM_CH  = rmf_pkg::NUM_CH;
    localparam int PIX_W   = rmf_pkg::PIX_W;
    localparam int LINE_W  = rmf_pkg::LINE_W;

    function automatic rmf_pkg::col_stat_t col_stat(
        input logic [CH_W-1:0] a,
        input logic [CH_W-1:0] b,
        input logic [CH_W-1:0] c
    );
        rmf_pkg::col_stat_t st;
        st.sum = rmf_pkg::SUM3_W'(a) + rmf_pkg::SUM3_W'(b) + rmf_pkg::SUM3_W'(c);
        st.lo  = (a < b) ? a : b;
        st.lo  = (c < st.lo) ? c : st.lo;
        st.hi  = (a > b) ? a : b;
        st.hi  = (c > st.hi) ? c : st.hi;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [rmf_pkg::CFG_W-1:0] frame_width_reg;
    logic [rmf_pkg::CFG_W-1:0] frame_height_reg;
    rmf_pkg::mode_t            filter_mode_reg;
    logic                      size_write;

    assign size_write = cfg_write && (cfg_index == rmf_pkg::REG_FRAME_WIDTH ||
                                      cfg_index == rmf_pkg::REG_FRAME_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= rmf_pkg::CFG_W'(640);
            frame_height_reg <= rmf_pkg::CFG_W'(480);
            filter_mode_reg  <= rmf_pkg::MODE_MEAN;
        end else if (cfg_write) begin
            unique case (cfg_index)
                rmf_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                rmf_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                rmf_pkg::REG_FILTER_MODE:  filter_mode_reg  <= rmf_pkg::mode_t'(cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    logic [WIDTH_W-1:0] eff_w;
    logic [ROW_W-1:0]   eff_h;

    always_comb begin
        if (frame_width_reg == '0) begin
            eff_w = WIDTH_W'(1);
        end else if (32'(frame_width_reg) > 32'(rmf_pkg::MAX_WIDTH)) begin
            eff_w = WIDTH_W'(rmf_pkg::MAX_WIDTH);
        end else begin
            eff_w = WIDTH_W'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            eff_h = ROW_W'(1);
        end else if (32'(frame_height_reg) > 32'(rmf_pkg::MAX_HEIGHT)) begin
            eff_h = ROW_W'(rmf_pkg::MAX_HEIGHT);
        end else begin
            eff_h = ROW_W'(frame_height_reg);
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake
    // ------------------------------------------------------------------
    logic                 s1_valid_reg;
    rmf_pkg::s1_ctrl_t    s1_ctrl_reg;
    logic [PIX_W-1:0]     s1_px_reg;
    logic                 s2_valid_reg;
    logic                 m_valid_reg;

    logic s2_advance, s2_free, s1_advance, s1_free, accept;

    assign s2_advance = s2_valid_reg && (!m_valid_reg || m_ready);
    assign s2_free    = !s2_valid_reg || s2_advance;
    assign s1_advance = s1_valid_reg && (!s1_ctrl_reg.emit || s2_free);
    assign s1_free    = !s1_valid_reg || s1_advance;
    assign s_ready    = s1_free;
    assign accept     = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Stage 0: frame positions and the decision for the incoming beat
    // ------------------------------------------------------------------
    logic [COL_W-1:0] in_col_reg,  in_col_next;
    logic [ROW_W-1:0] in_row_reg,  in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    logic [WIDTH_W-1:0] in_col_inc, out_col_inc;
    logic               in_wrap, out_wrap;
    logic [COL_W-1:0]   in_col_adv, out_col_adv;
    logic [ROW_W-1:0]   in_row_adv, out_row_adv;
    logic               out_last;
    logic               small_frame, in_done, warmup, interior, from_middle;
    rmf_pkg::s1_ctrl_t  s0_ctrl;
    logic [PIX_W-1:0]   s_px;

    assign s_px = {s_pixel_red, s_pixel_green, s_pixel_blue};

    always_comb begin
        in_col_inc  = WIDTH_W'(in_col_reg) + WIDTH_W'(1);
        in_wrap     = in_col_inc >= eff_w;
        in_col_adv  = in_wrap ? '0 : in_col_inc[COL_W-1:0];
        in_row_adv  = in_row_reg + ROW_W'(in_wrap);

        out_col_inc = WIDTH_W'(out_col_reg) + WIDTH_W'(1);
        out_wrap    = out_col_inc >= eff_w;
        out_col_adv = out_wrap ? '0 : out_col_inc[COL_W-1:0];
        out_row_adv = out_row_reg + ROW_W'(out_wrap);
        out_last    = out_row_adv >= eff_h;

        small_frame = (eff_w < WIDTH_W'(3)) || (eff_h < ROW_W'(3));
        in_done     = in_row_reg >= eff_h;
        // Fewer than one row plus two pixels seen: the first window is not complete yet.
        warmup      = (in_row_adv == '0) ||
                      (in_row_adv == ROW_W'(1) && in_col_adv < COL_W'(2));
        interior    = (out_row_reg != '0) && (out_col_reg != '0) &&
                      ((ROW_W+1)'(out_row_reg) + (ROW_W+1)'(2) <= (ROW_W+1)'(eff_h)) &&
                      ((WIDTH_W+1)'(out_col_reg) + (WIDTH_W+1)'(2) <= (WIDTH_W+1)'(eff_w));
        from_middle = (ROW_W+1)'(out_row_reg) + (ROW_W+1)'(1) >= (ROW_W+1)'(eff_h);

        s0_ctrl.wr   = 1'b0;
        s0_ctrl.emit = 1'b0;
        s0_ctrl.src  = rmf_pkg::SRC_INPUT;
        s0_ctrl.last = 1'b0;
        s0_ctrl.addr = in_col_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (small_frame) begin
            if (s_command == rmf_pkg::CMD_PIXEL) begin
                s0_ctrl.emit = 1'b1;
                in_col_next  = in_col_adv;
                in_row_next  = in_row_adv;
                out_col_next = out_col_adv;
                out_row_next = out_row_adv;
            end
        end else if (s_command == rmf_pkg::CMD_FLUSH || in_done) begin
            // Drain: the pending pixels sit in the line store unchanged.
            if (in_done) begin
                s0_ctrl.emit = 1'b1;
                s0_ctrl.src  = from_middle ? rmf_pkg::SRC_MIDDLE : rmf_pkg::SRC_UPPER;
                s0_ctrl.addr = out_col_reg;
                out_col_next = out_col_adv;
                out_row_next = out_row_adv;
            end
        end else begin
            s0_ctrl.wr  = 1'b1;
            in_col_next = in_col_adv;
            in_row_next = in_row_adv;
            if (!warmup) begin
                s0_ctrl.emit = 1'b1;
                s0_ctrl.src  = interior ? rmf_pkg::SRC_FILTER : rmf_pkg::SRC_CENTER;
                out_col_next = out_col_adv;
                out_row_next = out_row_adv;
            end
        end

        if (s0_ctrl.emit && out_last) begin
            s0_ctrl.last = 1'b1;
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (size_write) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (accept) begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line store: word holds {upper_line, middle_line} of one column.
    // ------------------------------------------------------------------
    logic [LINE_W-1:0] line_mem [rmf_pkg::MAX_WIDTH];
    logic [LINE_W-1:0] line_q_reg;
    logic              fwd_hit_reg;
    logic [LINE_W-1:0] fwd_data_reg;
    logic [LINE_W-1:0] line_word;
    logic [PIX_W-1:0]  up_old, mid_old;
    logic              mem_we;

    assign line_word = fwd_hit_reg ? fwd_data_reg : line_q_reg;
    assign up_old    = line_word[LINE_W-1:PIX_W];
    assign mid_old   = line_word[PIX_W-1:0];
    assign mem_we    = s1_advance && s1_ctrl_reg.wr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[s1_ctrl_reg.addr] <= {mid_old, s1_px_reg};
        end
        if (accept) begin
            line_q_reg <= line_mem[s0_ctrl.addr];
        end
    end

    // A beat accepted while stage 1 writes the same column would read the old word.
    // On an accepting edge stage 1 is either empty or leaves, so its write data is final here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (accept) begin
            fwd_hit_reg <= s1_valid_reg && s1_ctrl_reg.wr && (s1_ctrl_reg.addr == s0_ctrl.addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            fwd_data_reg <= {mid_old, s1_px_reg};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: window shift and per-column statistics
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept && (s0_ctrl.wr || s0_ctrl.emit)) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ctrl_reg <= s0_ctrl;
            s1_px_reg   <= s_px;
        end
    end

    // Two older window columns; index [column][row], column 1 holds the center.
    logic [PIX_W-1:0] win_reg [2][3];
    logic [PIX_W-1:0] cur_col [3][3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            cur_col[0][r] = win_reg[0][r];
            cur_col[1][r] = win_reg[1][r];
        end
        cur_col[2][0] = up_old;
        cur_col[2][1] = mid_old;
        cur_col[2][2] = s1_px_reg;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[0][r] <= win_reg[1][r];
                win_reg[1][r] <= cur_col[2][r];
            end
        end
    end

    rmf_pkg::col_stat_t s1_stat [3][NUM_CH];
    logic [PIX_W-1:0]   s1_result;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < NUM_CH; k++) begin
                s1_stat[c][k] = col_stat(cur_col[c][0][k*CH_W +: CH_W],
                                         cur_col[c][1][k*CH_W +: CH_W],
                                         cur_col[c][2][k*CH_W +: CH_W]);
            end
        end
        case (s1_ctrl_reg.src)
            rmf_pkg::SRC_INPUT:  s1_result = s1_px_reg;
            rmf_pkg::SRC_UPPER:  s1_result = up_old;
            rmf_pkg::SRC_MIDDLE: s1_result = mid_old;
            default:             s1_result = win_reg[1][1];
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 2: combine the three columns and apply the mode
    // ------------------------------------------------------------------
    rmf_pkg::col_stat_t s2_stat_reg [3][NUM_CH];
    logic [PIX_W-1:0]   s2_pix_reg;
    logic               s2_filt_reg;
    logic               s2_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_advance && s1_ctrl_reg.emit) begin
            s2_valid_reg <= 1'b1;
        end else if (s2_advance) begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && s1_ctrl_reg.emit) begin
            s2_stat_reg <= s1_stat;
            s2_pix_reg  <= s1_result;
            s2_filt_reg <= (s1_ctrl_reg.src == rmf_pkg::SRC_FILTER);
            s2_last_reg <= s1_ctrl_reg.last;
        end
    end

    logic [rmf_pkg::SUM9_W-1:0] tot_sum [NUM_CH];
    logic [rmf_pkg::PROD_W-1:0] mean_prod [NUM_CH];
    logic [CH_W-1:0]            win_lo [NUM_CH];
    logic [CH_W-1:0]            win_hi [NUM_CH];
    logic [PIX_W-1:0]           out_pix;

    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            tot_sum[k]   = rmf_pkg::SUM9_W'(s2_stat_reg[0][k].sum) +
                           rmf_pkg::SUM9_W'(s2_stat_reg[1][k].sum) +
                           rmf_pkg::SUM9_W'(s2_stat_reg[2][k].sum);
            mean_prod[k] = rmf_pkg::PROD_W'(tot_sum[k]) *
                           rmf_pkg::PROD_W'(rmf_pkg::MEAN_RECIP);
            win_lo[k]    = (s2_stat_reg[0][k].lo < s2_stat_reg[1][k].lo) ?
                           s2_stat_reg[0][k].lo : s2_stat_reg[1][k].lo;
            win_lo[k]    = (s2_stat_reg[2][k].lo < win_lo[k]) ? s2_stat_reg[2][k].lo : win_lo[k];
            win_hi[k]    = (s2_stat_reg[0][k].hi > s2_stat_reg[1][k].hi) ?
                           s2_stat_reg[0][k].hi : s2_stat_reg[1][k].hi;
            win_hi[k]    = (s2_stat_reg[2][k].hi > win_hi[k]) ? s2_stat_reg[2][k].hi : win_hi[k];

            if (!s2_filt_reg) begin
                out_pix[k*CH_W +: CH_W] = s2_pix_reg[k*CH_W +: CH_W];
            end else begin
                case (filter_mode_reg)
                    rmf_pkg::MODE_MEAN:
                        out_pix[k*CH_W +: CH_W] = mean_prod[k][rmf_pkg::MEAN_SHIFT +: CH_W];
                    rmf_pkg::MODE_MIN:  out_pix[k*CH_W +: CH_W] = win_lo[k];
                    rmf_pkg::MODE_MAX:  out_pix[k*CH_W +: CH_W] = win_hi[k];
                    default:            out_pix[k*CH_W +: CH_W] = s2_pix_reg[k*CH_W +: CH_W];
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] m_pix_reg;
    logic             m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s2_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_advance) begin
            m_pix_reg  <= out_pix;
            m_last_reg <= s2_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_red    = m_pix_reg[2*CH_W +: CH_W];
    assign m_out_green  = m_pix_reg[CH_W +: CH_W];
    assign m_out_blue   = m_pix_reg[0 +: CH_W];
    assign m_frame_last = m_last_reg;

endmodule

### rtl/rmf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the 3x3 rank/mean pixel filter, bound to its top level.
// Depends on rmf_pkg for port widths.
module rmf_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [rmf_pkg::CH_W-1:0]    m_out_red,
    input logic [rmf_pkg::CH_W-1:0]    m_out_green,
    input logic [rmf_pkg::CH_W-1:0]    m_out_blue,
    input logic                        m_frame_last
);

    // No result beat is offered right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat offered after reset");

    // The input side only stalls when a finished result is held back downstream.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while the result side is free");

    // A stalled result beat holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable({m_out_red, m_out_green, m_out_blue, m_frame_last})))
        else $error("result beat changed while stalled");

    // A result beat is withdrawn only after it was taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid) |-> $past(m_ready))
        else $error("result beat dropped without a transfer");

endmodule

bind window_3x3_rank_mean_filter rmf_checker u_rmf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_red    (m_out_red),
    .m_out_green  (m_out_green),
    .m_out_blue   (m_out_blue),
    .m_frame_last (m_frame_last)
);

### tb/window_3x3_rank_mean_filter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 3x3 rank/mean pixel filter: random frames with flushes,
// idling on both channels and a scoreboard that predicts every output beat.
// Depends on rmf_pkg and window_3x3_rank_mean_filter.
module window_3x3_rank_mean_filter_tb;

    localparam int RANDOM_ITEMS = 600;
    localparam int IDLE_GAP     = 12;    // covers the three-stage result latency
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 5000;

    localparam int CH_W       = rmf_pkg::CH_W;
    localparam int NUM_CH     = rmf_pkg::NUM_CH;
    localparam int PIX_W      = rmf_pkg::PIX_W;
    localparam int CFG_W      = rmf_pkg::CFG_W;
    localparam int MAX_WIDTH  = rmf_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT = rmf_pkg::MAX_HEIGHT;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } px_beat_t;

    class filter_scoreboard;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        rmf_pkg::mode_t   mode;
        logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
        logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
        logic [PIX_W-1:0] win [9];
        int unsigned      pix_col, pix_row, res_col, res_row;
        px_beat_t         expected_pixels [$];
        int               errors;

        function new();
            width_reg  = 640;
            height_reg = 480;
            mode       = rmf_pkg::MODE_MEAN;
            foreach (upper_mem[i]) begin
                upper_mem[i]  = '0;
                middle_mem[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            restart_frame();
            errors = 0;
        endfunction

        function void restart_frame();
            pix_col = 0;
            pix_row = 0;
            res_col = 0;
            res_row = 0;
        endfunction

        function int unsigned frame_w();
            int unsigned v;
            v = width_reg;
            if (v < 1) v = 1;
            if (v > MAX_WIDTH) v = MAX_WIDTH;
            return v;
        endfunction

        function int unsigned frame_h();
            int unsigned v;
            v = height_reg;
            if (v < 1) v = 1;
            if (v > MAX_HEIGHT) v = MAX_HEIGHT;
            return v;
        endfunction

        function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                rmf_pkg::REG_FRAME_WIDTH: begin
                    width_reg = val;
                    restart_frame();
                end
                rmf_pkg::REG_FRAME_HEIGHT: begin
                    height_reg = val;
                    restart_frame();
                end
                rmf_pkg::REG_FILTER_MODE: mode = rmf_pkg::mode_t'(val[1:0]);
                default: ;
            endcase
        endfunction

        function logic [PIX_W-1:0] filtered_center();
            logic [PIX_W-1:0] res;
            logic [CH_W-1:0]  s, lo, hi;
            int unsigned      sum;
            if (mode == rmf_pkg::MODE_PASS) return win[4];
            res = '0;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                sum = 0;
                lo  = 8'hFF;
                hi  = 8'h00;
                for (int i = 0; i < 9; i++) begin
                    s = win[i][ch*CH_W +: CH_W];
                    sum += s;
                    if (s < lo) lo = s;
                    if (s > hi) hi = s;
                end
                case (mode)
                    rmf_pkg::MODE_MEAN: res[ch*CH_W +: CH_W] = CH_W'(sum / 9);
                    rmf_pkg::MODE_MIN:  res[ch*CH_W +: CH_W] = lo;
                    default:            res[ch*CH_W +: CH_W] = hi;
                endcase
            end
            return res;
        endfunction

        function void push_pixel(logic [PIX_W-1:0] px, int unsigned w, int unsigned h);
            px_beat_t beat;
            beat.red   = px[23:16];
            beat.green = px[15:8];
            beat.blue  = px[7:0];
            res_col++;
            if (res_col >= w) begin
                res_col = 0;
                res_row++;
            end
            beat.last = (res_row >= h);
            if (beat.last) restart_frame();
            expected_pixels.push_back(beat);
        endfunction

        // Draining after the last pixel reads the column back out of the line store.
        function void drain_step(int unsigned w, int unsigned h);
            if (pix_row < h) return;
            if (res_row + 1 >= h) push_pixel(middle_mem[res_col], w, h);
            else push_pixel(upper_mem[res_col], w, h);
        endfunction

        function void note_pixel_beat(logic cmd, logic [PIX_W-1:0] px);
            int unsigned      w, h, x, cnt;
            logic [PIX_W-1:0] up_old, mid_old;
            w = frame_w();
            h = frame_h();
            if (w < 3 || h < 3) begin
                if (cmd == rmf_pkg::CMD_FLUSH) return;
                pix_col++;
                if (pix_col >= w) begin
                    pix_col = 0;
                    pix_row++;
                end
                push_pixel(px, w, h);
                return;
            end
            if (cmd == rmf_pkg::CMD_FLUSH || pix_row >= h) begin
                drain_step(w, h);
                return;
            end
            x       = pix_col;
            up_old  = upper_mem[x];
            mid_old = middle_mem[x];
            win[0] = win[1]; win[1] = win[2]; win[2] = up_old;
            win[3] = win[4]; win[4] = win[5]; win[5] = mid_old;
            win[6] = win[7]; win[7] = win[8]; win[8] = px;
            upper_mem[x]  = mid_old;
            middle_mem[x] = px;
            pix_col++;
            if (pix_col >= w) begin
                pix_col = 0;
                pix_row++;
            end
            cnt = pix_row * w + pix_col;
            if (cnt < w + 2) return;
            if (res_row >= 1 && res_row + 2 <= h && res_col >= 1 && res_col + 2 <= w)
                push_pixel(filtered_center(), w, h);
            else if (res_col + 1 == w)
                push_pixel(upper_mem[res_col], w, h);
            else
                push_pixel(win[4], w, h);
        endfunction

        function void check_output_beat(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                        logic [CH_W-1:0] b, logic last);
            px_beat_t want;
            if (expected_pixels.size() == 0) begin
                $error("unexpected output beat: red %0d green %0d blue %0d last %0d",
                       r, g, b, last);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (r !== want.red) begin
                $error("out_red: expected %0d, actual %0d", want.red, r);
                errors++;
            end
            if (g !== want.green) begin
                $error("out_green: expected %0d, actual %0d", want.green, g);
                errors++;
            end
            if (b !== want.blue) begin
                $error("out_blue: expected %0d, actual %0d", want.blue, b);
                errors++;
            end
            if (last !== want.last) begin
                $error("frame_last: expected %0d, actual %0d", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic              aclk;
    logic              aresetn       = 1'b0;
    logic              cfg_write     = 1'b0;
    logic [1:0]        cfg_index     = rmf_pkg::REG_FRAME_WIDTH;
    logic [CFG_W-1:0]  cfg_data      = '0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic              s_command     = rmf_pkg::CMD_PIXEL;
    logic [CH_W-1:0]   s_pixel_red   = '0;
    logic [CH_W-1:0]   s_pixel_green = '0;
    logic [CH_W-1:0]   s_pixel_blue  = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [CH_W-1:0]   m_out_red;
    logic [CH_W-1:0]   m_out_green;
    logic [CH_W-1:0]   m_out_blue;
    logic              m_frame_last;

    filter_scoreboard sb = new();

    int send_idle_pct = 8;
    int recv_idle_pct = 84;
    int hold_asked    = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int stall_cycles  = 0;
    int stim_items    = 0;

    window_3x3_rank_mean_filter uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_pixel_red   (s_pixel_red),
        .s_pixel_green (s_pixel_green),
        .s_pixel_blue  (s_pixel_blue),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .m_frame_last  (m_frame_last)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_pixel_beat(s_command, {s_pixel_red, s_pixel_green, s_pixel_blue});
            if (m_valid && m_ready)
                sb.check_output_beat(m_out_red, m_out_green, m_out_blue, m_frame_last);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    function automatic logic [CH_W-1:0] random_channel();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return CH_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        return {random_channel(), random_channel(), random_channel()};
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input logic cmd, input logic [PIX_W-1:0] px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_pixel_red   <= px[23:16];
        s_pixel_green <= px[15:8];
        s_pixel_blue  <= px[7:0];
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (IDLE_GAP) @(negedge aclk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.write_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic configure(input int w, input int h, input rmf_pkg::mode_t m);
        wait_idle();
        put_reg(rmf_pkg::REG_FRAME_WIDTH, CFG_W'(w));
        put_reg(rmf_pkg::REG_FRAME_HEIGHT, CFG_W'(h));
        put_reg(rmf_pkg::REG_FILTER_MODE, CFG_W'(m));
        cfg_write <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic change_mode(input rmf_pkg::mode_t m);
        wait_idle();
        put_reg(rmf_pkg::REG_FILTER_MODE, CFG_W'(m));
        cfg_write <= 1'b0;
        @(negedge aclk);
    endtask

    // One frame of pixels with stray flushes, then the drain beats. A frame may be cut
    // short, in which case the next size write throws it away.
    task automatic run_frame(input int w, input int h, output bit cut_short);
        int  total, cut, switch_at, k;
        bit  tiny;
        total     = w * h;
        tiny      = (w < 3) || (h < 3);
        cut       = total;
        switch_at = -1;
        if (!tiny && $urandom_range(9) == 0) cut = $urandom_range(total - 1, 1);
        if (!tiny && $urandom_range(6) == 0) switch_at = $urandom_range(total - 1, 1);
        cut_short = (cut < total);
        for (k = 0; k < cut; k++) begin
            if (k == switch_at) change_mode(rmf_pkg::mode_t'($urandom_range(3)));
            if ($urandom_range(99) < 5) send_beat(rmf_pkg::CMD_FLUSH, random_pixel());
            send_beat(rmf_pkg::CMD_PIXEL, random_pixel());
            stim_items++;
        end
        if (cut_short) return;
        // The pixel data of a drain beat sent as a pixel is dropped.
        if (!tiny) begin
            for (k = 0; k <= w; k++) begin
                send_beat($urandom_range(1) ? rmf_pkg::CMD_FLUSH : rmf_pkg::CMD_PIXEL,
                          random_pixel());
                stim_items++;
            end
        end
        repeat ($urandom_range(2)) send_beat(rmf_pkg::CMD_FLUSH, random_pixel());
    endtask

    initial begin
        int  w, h, k;
        bit  cut_short, pressure_done;
        pressure_done = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // 3x3 frame: flush too early, corner values, then drains with dropped pixels.
        configure(3, 3, rmf_pkg::MODE_MEAN);
        send_beat(rmf_pkg::CMD_FLUSH, 24'hFFFFFF);
        for (k = 0; k < 9; k++)
            send_beat(rmf_pkg::CMD_PIXEL, {k[0] ? 8'h00 : 8'hFF, k[0] ? 8'hFF : 8'h00,
                                           (k == 4) ? 8'hFF : 8'h00});
        send_beat(rmf_pkg::CMD_FLUSH, 24'h000000);
        send_beat(rmf_pkg::CMD_PIXEL, 24'hFFFFFF);
        send_beat(rmf_pkg::CMD_FLUSH, 24'hFFFFFF);
        send_beat(rmf_pkg::CMD_PIXEL, 24'h000000);
        // Two-pixel frame passes straight through; the flush gives nothing.
        configure(2, 1, rmf_pkg::MODE_PASS);
        send_beat(rmf_pkg::CMD_PIXEL, 24'h00FF00);
        send_beat(rmf_pkg::CMD_FLUSH, 24'hFF00FF);
        send_beat(rmf_pkg::CMD_PIXEL, 24'hFF00FF);
        // Partial frame, abandoned by the next size write.
        configure(4, 3, rmf_pkg::MODE_MAX);
        for (k = 0; k < 7; k++) send_beat(rmf_pkg::CMD_PIXEL, random_pixel());

        while (stim_items < RANDOM_ITEMS || !pressure_done) begin
            if (stim_items < RANDOM_ITEMS / 3) begin
                send_idle_pct = 8;
                recv_idle_pct = 84;
            end else if (stim_items < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 84;
                recv_idle_pct = 8;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (send_idle_pct == 0 && !pressure_done) begin
                // Long receiver hold-off while the sender keeps pushing a large frame.
                pressure_done = 1'b1;
                configure(32, 6, rmf_pkg::mode_t'($urandom_range(3)));
                hold_asked++;
                run_frame(32, 6, cut_short);
                continue;
            end
            if ($urandom_range(6) == 0) begin
                if ($urandom_range(1)) begin
                    w = $urandom_range(2, 1);
                    h = $urandom_range(6, 1);
                end else begin
                    w = $urandom_range(12, 1);
                    h = $urandom_range(2, 1);
                end
            end else begin
                w = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 3);
                h = $urandom_range(7, 3);
            end
            configure(w, h, rmf_pkg::mode_t'($urandom_range(3)));
            // Sometimes a second frame follows straight on with the same settings.
            repeat (1 + ($urandom_range(3) == 0)) begin
                run_frame(w, h, cut_short);
                if (cut_short) break;
            end
        end

        wait_idle();
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
